// ----- rtl/usvg_pkg.sv -----
package usvg_pkg;

   localparam int MAX_RINGS    = 256;
   localparam int MAX_SECTORS  = 256;
   localparam int SERIES_TERMS = 6;

   // Fraction bits of the index divider: index / (count - 1) with 17 bits after the point.
   localparam int DIV_FRAC  = 17;
   localparam int DIV_LAT   = DIV_FRAC + 1;
   localparam int SIN_LAT   = 3 + 3 * SERIES_TERMS + 1;
   localparam int SCALE_LAT = 4;
   localparam int TOTAL_LAT = DIV_LAT + SIN_LAT + SCALE_LAT;
   localparam int TEX_LAT   = SIN_LAT + SCALE_LAT;

   localparam logic [31:0] PI_Q30  = 32'd3373259426;
   localparam logic [30:0] ONE_Q30 = 31'd1073741824;

   localparam logic [1:0] CSR_RADIUS  = 2'd0;
   localparam logic [1:0] CSR_RINGS   = 2'd1;
   localparam logic [1:0] CSR_SECTORS = 2'd2;

   typedef struct packed {
      logic [15:0] upper_left;
      logic [15:0] upper_right;
      logic [15:0] lower_right;
      logic [15:0] lower_left;
   } corner_type;

   typedef struct packed {
      logic [16:0] u;
      logic [16:0] v;
   } tex_type;

   typedef struct packed {
      logic signed [31:0] sin_p;
      logic signed [31:0] y30;
      logic signed [31:0] cos_a;
      logic signed [31:0] sin_a;
   } trig_type;

   // Divisor of term k of the sine or cosine series.
   function automatic logic [7:0] series_div(input int k, input logic use_cos);
      logic [7:0] d;
      d = 8'd1;
      case (k)
         1: d = use_cos ? 8'd2   : 8'd6;
         2: d = use_cos ? 8'd12  : 8'd20;
         3: d = use_cos ? 8'd30  : 8'd42;
         4: d = use_cos ? 8'd56  : 8'd72;
         5: d = use_cos ? 8'd90  : 8'd110;
         6: d = use_cos ? 8'd132 : 8'd156;
         default: d = 8'd1;
      endcase
      return d;
   endfunction

   // floor(2^31 / divisor) for the same terms.
   function automatic logic [30:0] series_recip(input int k, input logic use_cos);
      logic [30:0] m;
      m = 31'd0;
      case (k)
         1: m = use_cos ? 31'd1073741824 : 31'd357913941;
         2: m = use_cos ? 31'd178956970  : 31'd107374182;
         3: m = use_cos ? 31'd71582788   : 31'd51130563;
         4: m = use_cos ? 31'd38347922   : 31'd29826161;
         5: m = use_cos ? 31'd23860929   : 31'd19522578;
         6: m = use_cos ? 31'd16268815   : 31'd13765920;
         default: m = 31'd0;
      endcase
      return m;
   endfunction

endpackage

// ----- rtl/usvg_div.sv -----
// Restoring divider, one quotient bit per stage: quo = floor(num * 2^17 / den), num <= den.
module usvg_div
   import usvg_pkg::*;
(
   input  logic                clock,
   input  logic [7:0]          num,
   input  logic [7:0]          den,
   output logic [DIV_FRAC:0]   quo
);

   logic [7:0]        rem_ff [0:DIV_FRAC];
   logic [7:0]        den_ff [0:DIV_FRAC];
   logic [DIV_FRAC:0] quo_ff [0:DIV_FRAC];

   always_ff @(posedge clock) begin
      den_ff[0] <= den;
      if (num >= den) begin
         rem_ff[0] <= num - den;
         quo_ff[0] <= (DIV_FRAC + 1)'(1);
      end else begin
         rem_ff[0] <= num;
         quo_ff[0] <= '0;
      end
   end

   for (genvar j = 1; j <= DIV_FRAC; j++) begin : g_step
      logic [8:0] trial;
      logic       fits;
      always_comb begin
         trial = {rem_ff[j-1], 1'b0};
         fits  = trial >= {1'b0, den_ff[j-1]};
      end
      always_ff @(posedge clock) begin
         den_ff[j] <= den_ff[j-1];
         quo_ff[j] <= {quo_ff[j-1][DIV_FRAC-1:0], fits};
         if (fits) begin
            rem_ff[j] <= 8'(trial - {1'b0, den_ff[j-1]});
         end else begin
            rem_ff[j] <= trial[7:0];
         end
      end
   end

   assign quo = quo_ff[DIV_FRAC];

endmodule

// ----- rtl/usvg_sin.sv -----
// Sine of a 16-bit phase (full turn = 2^16) as a signed Q30 value, via quadrant folding
// and a six-term Taylor series, one series term per three stages.
module usvg_sin
   import usvg_pkg::*;
(
   input  logic               clock,
   input  logic [15:0]        phase,
   output logic signed [31:0] value
);

   logic [14:0] fold;
   logic        cos_in;
   logic [13:0] g_in;

   always_comb begin
      fold   = phase[14] ? (15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
      cos_in = fold > 15'd8192;
      g_in   = cos_in ? 14'(15'd16384 - fold) : fold[13:0];
   end

   logic [13:0] g_ff;
   logic        cos1_ff, neg1_ff;
   logic [29:0] x_ff;
   logic        cos2_ff, neg2_ff;
   logic [45:0] gx;

   assign gx = {32'd0, g_ff} * {14'd0, PI_Q30};

   always_ff @(posedge clock) begin
      g_ff    <= g_in;
      cos1_ff <= cos_in;
      neg1_ff <= phase[15];
      x_ff    <= gx[44:15];
      cos2_ff <= cos1_ff;
      neg2_ff <= neg1_ff;
   end

   logic [30:0]        term_ff [0:SERIES_TERMS];
   logic signed [31:0] sum_ff  [0:SERIES_TERMS];
   logic [29:0]        x2_ff   [0:SERIES_TERMS];
   logic               cos_ff  [0:SERIES_TERMS];
   logic               neg_ff  [0:SERIES_TERMS];
   logic [59:0]        xsq;
   logic [30:0]        term0;

   always_comb begin
      xsq   = {30'd0, x_ff} * {30'd0, x_ff};
      term0 = cos2_ff ? ONE_Q30 : {1'b0, x_ff};
   end

   always_ff @(posedge clock) begin
      x2_ff[0]   <= xsq[59:30];
      term_ff[0] <= term0;
      sum_ff[0]  <= $signed({1'b0, term0});
      cos_ff[0]  <= cos2_ff;
      neg_ff[0]  <= neg2_ff;
   end

   for (genvar k = 1; k <= SERIES_TERMS; k++) begin : g_term
      localparam logic [7:0]  D_SIN = series_div(k, 1'b0);
      localparam logic [7:0]  D_COS = series_div(k, 1'b1);
      localparam logic [30:0] M_SIN = series_recip(k, 1'b0);
      localparam logic [30:0] M_COS = series_recip(k, 1'b1);

      logic [60:0]        prod_ff;
      logic [29:0]        x2a_ff, x2b_ff;
      logic signed [31:0] suma_ff, sumb_ff;
      logic               cosa_ff, cosb_ff, nega_ff, negb_ff;
      logic [29:0]        v_ff;
      logic [60:0]        vm_ff;
      logic [29:0]        v_in;
      logic [60:0]        vm_in;
      logic [7:0]         dsel;
      logic [29:0]        q0;
      logic [37:0]        rem;
      logic [29:0]        q_in;
      logic signed [31:0] sum_in;

      always_comb begin
         v_in   = prod_ff[59:30];
         vm_in  = {31'd0, v_in} * {30'd0, (cosa_ff ? M_COS : M_SIN)};
         dsel   = cosb_ff ? D_COS : D_SIN;
         q0     = vm_ff[60:31];
         rem    = {8'd0, v_ff} - ({8'd0, q0} * {30'd0, dsel});
         q_in   = q0 + 30'(rem >= {30'd0, dsel});
         sum_in = (k % 2 == 1) ? sumb_ff - $signed({2'b00, q_in})
                               : sumb_ff + $signed({2'b00, q_in});
      end

      always_ff @(posedge clock) begin
         prod_ff     <= {30'd0, term_ff[k-1]} * {31'd0, x2_ff[k-1]};
         x2a_ff      <= x2_ff[k-1];
         suma_ff     <= sum_ff[k-1];
         cosa_ff     <= cos_ff[k-1];
         nega_ff     <= neg_ff[k-1];
         v_ff        <= v_in;
         vm_ff       <= vm_in;
         x2b_ff      <= x2a_ff;
         sumb_ff     <= suma_ff;
         cosb_ff     <= cosa_ff;
         negb_ff     <= nega_ff;
         term_ff[k]  <= {1'b0, q_in};
         sum_ff[k]   <= sum_in;
         x2_ff[k]    <= x2b_ff;
         cos_ff[k]   <= cosb_ff;
         neg_ff[k]   <= negb_ff;
      end
   end

   logic signed [31:0] value_ff;

   always_ff @(posedge clock) begin
      value_ff <= neg_ff[SERIES_TERMS] ? -sum_ff[SERIES_TERMS] : sum_ff[SERIES_TERMS];
   end

   assign value = value_ff;

endmodule

// ----- rtl/usvg_scale.sv -----
// Forms the Q1.14 normal from the Q30 sines and scales it by the radius into Q8.8.
module usvg_scale
   import usvg_pkg::*;
(
   input  logic               clock,
   input  trig_type           trig,
   input  logic [15:0]        radius,
   output logic signed [15:0] norm_x,
   output logic signed [15:0] norm_y,
   output logic signed [15:0] norm_z,
   output logic signed [16:0] pos_x,
   output logic signed [16:0] pos_y,
   output logic signed [16:0] pos_z
);

   function automatic logic signed [15:0] round16(input logic signed [31:0] v);
      logic [31:0] mag;
      logic [31:0] r;
      mag = v[31] ? 32'(-v) : 32'(v);
      r   = (mag + 32'd32768) >> 16;
      return v[31] ? -$signed(r[15:0]) : $signed(r[15:0]);
   endfunction

   function automatic logic signed [15:0] round46(input logic signed [63:0] v);
      logic [63:0] mag;
      logic [63:0] r;
      mag = v[63] ? 64'(-v) : 64'(v);
      r   = mag + (64'd1 << 45);
      return v[63] ? -$signed(r[61:46]) : $signed(r[61:46]);
   endfunction

   function automatic logic signed [16:0] round14(input logic signed [32:0] v);
      logic [32:0] mag;
      logic [32:0] r;
      mag = v[32] ? 33'(-v) : 33'(v);
      r   = mag + 33'd8192;
      return v[32] ? -$signed(r[30:14]) : $signed(r[30:14]);
   endfunction

   logic signed [63:0] pnx_ff, pnz_ff;
   logic signed [15:0] ny1_ff;
   logic signed [15:0] nx2_ff, ny2_ff, nz2_ff;
   logic signed [15:0] nx3_ff, ny3_ff, nz3_ff;
   logic signed [32:0] px_ff, py_ff, pz_ff;
   logic signed [15:0] nx4_ff, ny4_ff, nz4_ff;
   logic signed [16:0] posx_ff, posy_ff, posz_ff;
   logic signed [32:0] rad_ext;

   assign rad_ext = $signed({17'd0, radius});

   always_ff @(posedge clock) begin
      pnx_ff  <= 64'(trig.cos_a) * 64'(trig.sin_p);
      pnz_ff  <= 64'(trig.sin_a) * 64'(trig.sin_p);
      ny1_ff  <= round16(trig.y30);
      nx2_ff  <= round46(pnx_ff);
      nz2_ff  <= round46(pnz_ff);
      ny2_ff  <= ny1_ff;
      px_ff   <= 33'(nx2_ff) * rad_ext;
      py_ff   <= 33'(ny2_ff) * rad_ext;
      pz_ff   <= 33'(nz2_ff) * rad_ext;
      nx3_ff  <= nx2_ff;
      ny3_ff  <= ny2_ff;
      nz3_ff  <= nz2_ff;
      posx_ff <= round14(px_ff);
      posy_ff <= round14(py_ff);
      posz_ff <= round14(pz_ff);
      nx4_ff  <= nx3_ff;
      ny4_ff  <= ny3_ff;
      nz4_ff  <= nz3_ff;
   end

   assign norm_x = nx4_ff;
   assign norm_y = ny4_ff;
   assign norm_z = nz4_ff;
   assign pos_x  = posx_ff;
   assign pos_y  = posy_ff;
   assign pos_z  = posz_ff;

endmodule

// ----- rtl/uv_sphere_vertex_generator_core.sv -----
// UV sphere vertex generator.
// An item is one grid point (ring, sector). It is accepted at a rising clock edge at which
// start is high and busy is low; busy is always low, so the block takes one item in every
// cycle. Each item gives exactly one result: rsp_valid is high for one cycle together with
// the position, normal, texture coordinates and quad corner indices of that point.
// On its way to the result an item passes through one input stage, an 18-stage index
// divider (one quotient bit per stage), a 22-stage sine pipeline (three stages per series
// term) and four stages of normal and radius scaling.
// Throughput is one item per cycle, fixed by the fully pipelined divider and sine units.
// The receiver cannot stall; results are presented once and never held.
// Configuration writes on the csr_ port take effect at the next edge and must only be made
// while no item is in flight. Synchronous reset empties the pipeline (no results appear)
// and loads radius 1.0, 16 rings and 16 sectors.
module uv_sphere_vertex_generator_core
   import usvg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [7:0]         req_ring_index,
   input  logic [7:0]         req_sector_index,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output logic               rsp_valid,
   output logic signed [16:0] rsp_pos_x,
   output logic signed [16:0] rsp_pos_y,
   output logic signed [16:0] rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic [16:0]        rsp_tex_u,
   output logic [16:0]        rsp_tex_v,
   output logic [15:0]        rsp_corner_upper_left,
   output logic [15:0]        rsp_corner_upper_right,
   output logic [15:0]        rsp_corner_lower_right,
   output logic [15:0]        rsp_corner_lower_left
);

   // Configuration registers.
   logic [15:0] radius_ff;
   logic [8:0]  rings_ff, sectors_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= 16'd256;
         rings_ff   <= 9'd16;
         sectors_ff <= 9'd16;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RADIUS:  radius_ff  <= csr_wdata;
            CSR_RINGS:   rings_ff   <= csr_wdata[8:0];
            CSR_SECTORS: sectors_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // Input stage: clamp the counts and saturate the indices to the last ring and sector.
   logic [8:0] rings_in, sectors_in;
   logic [7:0] rd_in, sd_in, r_in, s_in;

   always_comb begin
      rings_in   = (rings_ff < 9'd2) ? 9'd2
                 : ((rings_ff > 9'(MAX_RINGS)) ? 9'(MAX_RINGS) : rings_ff);
      sectors_in = (sectors_ff < 9'd2) ? 9'd2
                 : ((sectors_ff > 9'(MAX_SECTORS)) ? 9'(MAX_SECTORS) : sectors_ff);
      rd_in      = 8'(rings_in - 9'd1);
      sd_in      = 8'(sectors_in - 9'd1);
      r_in       = (req_ring_index > rd_in) ? rd_in : req_ring_index;
      s_in       = (req_sector_index > sd_in) ? sd_in : req_sector_index;
   end

   logic       v0_ff;
   logic [7:0] r0_ff, s0_ff, rd0_ff, sd0_ff;
   logic [8:0] sectors0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start & ~busy;
      end
      r0_ff       <= r_in;
      s0_ff       <= s_in;
      rd0_ff      <= rd_in;
      sd0_ff      <= sd_in;
      sectors0_ff <= sectors_in;
   end

   // Quad corners; all zero on the last ring or the last sector, where no quad starts.
   corner_type corner_in;
   logic [16:0] row_base;
   logic [15:0] ll;

   always_comb begin
      row_base = {9'd0, r0_ff} * {8'd0, sectors0_ff};
      ll       = row_base[15:0] + {8'd0, s0_ff};
      if ((r0_ff == rd0_ff) || (s0_ff == sd0_ff)) begin
         corner_in = '0;
      end else begin
         corner_in.lower_left  = ll;
         corner_in.lower_right = ll + 16'd1;
         corner_in.upper_left  = ll + {7'd0, sectors0_ff};
         corner_in.upper_right = ll + {7'd0, sectors0_ff} + 16'd1;
      end
   end

   // Index over count minus one, with 17 fraction bits; texture and phase follow by rounding.
   logic [DIV_FRAC:0] quo_r, quo_s;

   usvg_div u_div_ring (
      .clock (clock),
      .num   (r0_ff),
      .den   (rd0_ff),
      .quo   (quo_r)
   );

   usvg_div u_div_sector (
      .clock (clock),
      .num   (s0_ff),
      .den   (sd0_ff),
      .quo   (quo_s)
   );

   tex_type     tex_in;
   logic [18:0] qr_half, qr_quarter, qs_half;
   logic [15:0] ph_polar, ph_y, ph_az, ph_cos;

   always_comb begin
      qr_half    = {1'b0, quo_r} + 19'd1;
      qr_quarter = {1'b0, quo_r} + 19'd2;
      qs_half    = {1'b0, quo_s} + 19'd1;
      tex_in.v   = qr_half[17:1];
      tex_in.u   = qs_half[17:1];
      ph_polar   = qr_quarter[17:2];
      ph_y       = ph_polar - 16'd16384;
      ph_az      = qs_half[16:1];
      ph_cos     = ph_az + 16'd16384;
   end

   trig_type           trig;
   logic signed [31:0] trig_sin_p, trig_y30, trig_cos_a, trig_sin_a;

   usvg_sin u_sin_polar (.clock(clock), .phase(ph_polar), .value(trig_sin_p));
   usvg_sin u_sin_y     (.clock(clock), .phase(ph_y),     .value(trig_y30));
   usvg_sin u_cos_az    (.clock(clock), .phase(ph_cos),   .value(trig_cos_a));
   usvg_sin u_sin_az    (.clock(clock), .phase(ph_az),    .value(trig_sin_a));

   assign trig = {trig_sin_p, trig_y30, trig_cos_a, trig_sin_a};

   usvg_scale u_scale (
      .clock  (clock),
      .trig   (trig),
      .radius (radius_ff),
      .norm_x (rsp_norm_x),
      .norm_y (rsp_norm_y),
      .norm_z (rsp_norm_z),
      .pos_x  (rsp_pos_x),
      .pos_y  (rsp_pos_y),
      .pos_z  (rsp_pos_z)
   );

   // Side data travels alongside the arithmetic so that it lines up with the scaled outputs.
   logic       valid_ff  [0:TOTAL_LAT-1];
   corner_type corner_ff [0:TOTAL_LAT-1];
   tex_type    tex_ff    [0:TEX_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOTAL_LAT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= v0_ff;
         for (int i = 1; i < TOTAL_LAT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
      corner_ff[0] <= corner_in;
      for (int i = 1; i < TOTAL_LAT; i++) begin
         corner_ff[i] <= corner_ff[i-1];
      end
      tex_ff[0] <= tex_in;
      for (int i = 1; i < TEX_LAT; i++) begin
         tex_ff[i] <= tex_ff[i-1];
      end
   end

   assign rsp_valid              = valid_ff[TOTAL_LAT-1];
   assign rsp_tex_u              = tex_ff[TEX_LAT-1].u;
   assign rsp_tex_v              = tex_ff[TEX_LAT-1].v;
   assign rsp_corner_upper_left  = corner_ff[TOTAL_LAT-1].upper_left;
   assign rsp_corner_upper_right = corner_ff[TOTAL_LAT-1].upper_right;
   assign rsp_corner_lower_right = corner_ff[TOTAL_LAT-1].lower_right;
   assign rsp_corner_lower_left  = corner_ff[TOTAL_LAT-1].lower_left;

   // A reset cycle leaves the pipeline empty.
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // Corners either mark a quad or are all zero.
   a_corner_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_corner_upper_right == rsp_corner_upper_left + 16'd1 &&
                     rsp_corner_lower_right == rsp_corner_lower_left + 16'd1) ||
                    (rsp_corner_upper_left == 16'd0 && rsp_corner_upper_right == 16'd0 &&
                     rsp_corner_lower_left == 16'd0 && rsp_corner_lower_right == 16'd0))
      else $error("inconsistent quad corners");

   // Texture coordinates never pass 1.0.
   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tex_u <= 17'd65536 && rsp_tex_v <= 17'd65536)
      else $error("texture coordinate out of range");

   // The normal stays within the unit range.
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_norm_x >= -16'sd16384 && rsp_norm_x <= 16'sd16384 &&
                    rsp_norm_y >= -16'sd16384 && rsp_norm_y <= 16'sd16384 &&
                    rsp_norm_z >= -16'sd16384 && rsp_norm_z <= 16'sd16384)
      else $error("normal out of range");

endmodule

// ----- test/tb_uv_sphere_vertex_generator_core.sv -----
module tb_uv_sphere_vertex_generator_core;
   import usvg_pkg::*;

   // One result as the block should present it.
   typedef struct {
      logic signed [16:0] pos_x;
      logic signed [16:0] pos_y;
      logic signed [16:0] pos_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic [16:0]        tex_u;
      logic [16:0]        tex_v;
      logic [15:0]        ul;
      logic [15:0]        ur;
      logic [15:0]        lr;
      logic [15:0]        ll;
   } vertex_type;

   // One grid point waiting to be driven.
   typedef struct {
      logic [7:0] ring;
      logic [7:0] sector;
   } point_type;

   localparam longint unsigned QUARTER = 64'd1073741824;
   localparam longint unsigned EIGHTH  = 64'd536870912;
   localparam longint unsigned PI30    = 64'd3373259426;
   localparam int WATCHDOG_LIMIT = 5000;
   // An index past the three registers; writes to it are dropped.
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [7:0] req_ring_index = '0;
   logic [7:0] req_sector_index = '0;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic busy;
   logic rsp_valid;
   logic signed [16:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [15:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic [16:0] rsp_tex_u, rsp_tex_v;
   logic [15:0] rsp_corner_upper_left, rsp_corner_upper_right;
   logic [15:0] rsp_corner_lower_right, rsp_corner_lower_left;

   uv_sphere_vertex_generator_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_ring_index(req_ring_index), .req_sector_index(req_sector_index),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_pos_z(rsp_pos_z),
      .rsp_norm_x(rsp_norm_x), .rsp_norm_y(rsp_norm_y), .rsp_norm_z(rsp_norm_z),
      .rsp_tex_u(rsp_tex_u), .rsp_tex_v(rsp_tex_v),
      .rsp_corner_upper_left(rsp_corner_upper_left),
      .rsp_corner_upper_right(rsp_corner_upper_right),
      .rsp_corner_lower_right(rsp_corner_lower_right),
      .rsp_corner_lower_left(rsp_corner_lower_left)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The testbench's own copy of the configuration registers, as written.
   logic [15:0] radius_reg = 16'd256;
   logic [8:0]  rings_reg  = 9'd16;
   logic [8:0]  sectors_reg = 9'd16;

   point_type  point_q[$];
   vertex_type vertex_q[$];
   int idle_pct = 0;
   int errors = 0;
   int accepted = 0;
   int checked = 0;
   int settings_run = 0;
   int quiet_cycles = 0;

   // Series evaluation in Q30, same truncations the hardware performs.
   function automatic longint sine_poly(input longint unsigned x);
      longint unsigned x2, term;
      longint sum;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= SERIES_TERMS; k++) begin
         term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
         sum = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
      end
      return sum;
   endfunction

   function automatic longint cosine_poly(input longint unsigned x);
      longint unsigned x2, term;
      longint sum;
      x2 = (x * x) >> 30;
      term = QUARTER;
      sum = longint'(QUARTER);
      for (int k = 1; k <= SERIES_TERMS; k++) begin
         term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
         sum = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
      end
      return sum;
   endfunction

   // Sine of a first-quadrant phase in units of 2^-32 turn.
   function automatic longint quarter_sine(input longint unsigned t);
      if (t <= EIGHTH) return sine_poly((t * PI30) >> 31);
      return cosine_poly(((QUARTER - t) * PI30) >> 31);
   endfunction

   function automatic longint phase_sine(input logic [31:0] p);
      longint unsigned t;
      t = longint'(p[29:0]);
      case (p[31:30])
         2'd0: return quarter_sine(t);
         2'd1: return quarter_sine(QUARTER - t);
         2'd2: return -quarter_sine(t);
         default: return -quarter_sine(QUARTER - t);
      endcase
   endfunction

   // Rounds v / 2^sh half away from zero.
   function automatic longint round_away(input longint v, input int sh);
      longint unsigned m;
      m = (v < 0) ? longint'(-v) : longint'(v);
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic vertex_type sphere_vertex(input logic [7:0] ring,
                                                input logic [7:0] sector);
      vertex_type o;
      longint unsigned rings, sectors, rd, sd, r, s, ph_polar, ph_az;
      logic [31:0] p_polar, p_az;
      longint sin_p, y30, cos_a, sin_a, nx, ny, nz, rad;
      rings = (rings_reg < 2) ? 2 : (rings_reg > MAX_RINGS ? MAX_RINGS : rings_reg);
      sectors = (sectors_reg < 2) ? 2 : (sectors_reg > MAX_SECTORS ? MAX_SECTORS : sectors_reg);
      rd = rings - 1;
      sd = sectors - 1;
      r = (ring > rd) ? rd : ring;
      s = (sector > sd) ? sd : sector;
      ph_polar = (2 * r * 64'd32768 + rd) / (2 * rd);
      ph_az = ((2 * s * 64'd65536 + sd) / (2 * sd)) & 64'hFFFF;
      p_polar = 32'(ph_polar << 16);
      p_az = 32'(ph_az << 16);
      sin_p = phase_sine(p_polar);
      y30 = phase_sine(p_polar - 32'h4000_0000);
      cos_a = phase_sine(p_az + 32'h4000_0000);
      sin_a = phase_sine(p_az);
      nx = round_away(cos_a * sin_p, 46);
      ny = round_away(y30, 16);
      nz = round_away(sin_a * sin_p, 46);
      rad = longint'(radius_reg);
      o.pos_x = 17'(round_away(nx * rad, 14));
      o.pos_y = 17'(round_away(ny * rad, 14));
      o.pos_z = 17'(round_away(nz * rad, 14));
      o.norm_x = 16'(nx);
      o.norm_y = 16'(ny);
      o.norm_z = 16'(nz);
      o.tex_u = 17'((2 * s * 64'd65536 + sd) / (2 * sd));
      o.tex_v = 17'((2 * r * 64'd65536 + rd) / (2 * rd));
      // No quad starts on the last ring or the last sector.
      if (r == rd || s == sd) begin
         o.ul = '0; o.ur = '0; o.lr = '0; o.ll = '0;
      end else begin
         o.ul = 16'((r + 1) * sectors + s);
         o.ur = 16'((r + 1) * sectors + s + 1);
         o.lr = 16'(r * sectors + s + 1);
         o.ll = 16'(r * sectors + s);
      end
      return o;
   endfunction

   // Driver: an item on the ports is accepted when start is high and busy low; the next
   // one is then loaded unless the sender decides to idle this cycle.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (!(start && busy)) begin
            if (start) begin
               vertex_q.insert(vertex_q.size(),
                               sphere_vertex(req_ring_index, req_sector_index));
               accepted++;
            end
            if (point_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
               point_type pt;
               pt = point_q.pop_front();
               req_ring_index <= pt.ring;
               req_sector_index <= pt.sector;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed result is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (vertex_q.size() == 0) begin
            $error("result arrived with no item outstanding");
            errors++;
         end else begin
            vertex_type e;
            e = vertex_q.pop_front();
            checked++;
            if (rsp_pos_x !== e.pos_x) begin
               $error("pos_x expected %0d got %0d", e.pos_x, rsp_pos_x); errors++;
            end
            if (rsp_pos_y !== e.pos_y) begin
               $error("pos_y expected %0d got %0d", e.pos_y, rsp_pos_y); errors++;
            end
            if (rsp_pos_z !== e.pos_z) begin
               $error("pos_z expected %0d got %0d", e.pos_z, rsp_pos_z); errors++;
            end
            if (rsp_norm_x !== e.norm_x) begin
               $error("norm_x expected %0d got %0d", e.norm_x, rsp_norm_x); errors++;
            end
            if (rsp_norm_y !== e.norm_y) begin
               $error("norm_y expected %0d got %0d", e.norm_y, rsp_norm_y); errors++;
            end
            if (rsp_norm_z !== e.norm_z) begin
               $error("norm_z expected %0d got %0d", e.norm_z, rsp_norm_z); errors++;
            end
            if (rsp_tex_u !== e.tex_u) begin
               $error("tex_u expected %0d got %0d", e.tex_u, rsp_tex_u); errors++;
            end
            if (rsp_tex_v !== e.tex_v) begin
               $error("tex_v expected %0d got %0d", e.tex_v, rsp_tex_v); errors++;
            end
            if (rsp_corner_upper_left !== e.ul) begin
               $error("corner_upper_left expected %0d got %0d", e.ul, rsp_corner_upper_left);
               errors++;
            end
            if (rsp_corner_upper_right !== e.ur) begin
               $error("corner_upper_right expected %0d got %0d", e.ur, rsp_corner_upper_right);
               errors++;
            end
            if (rsp_corner_lower_right !== e.lr) begin
               $error("corner_lower_right expected %0d got %0d", e.lr, rsp_corner_lower_right);
               errors++;
            end
            if (rsp_corner_lower_left !== e.ll) begin
               $error("corner_lower_left expected %0d got %0d", e.ll, rsp_corner_lower_left);
               errors++;
            end
         end
      end
   end

   // Watchdog: the run is stuck if neither an item nor a result moves for too long.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Writes keep the enable high back to back; the caller lowers it afterwards.
   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_RADIUS:  radius_reg = val;
         CSR_RINGS:   rings_reg = val[8:0];
         CSR_SECTORS: sectors_reg = val[8:0];
         default: ;  // Writes beyond the three registers are dropped.
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Waits until every item has been driven and answered, then lets the pipe drain.
   task automatic wait_drained();
      while (point_q.size() > 0 || start || vertex_q.size() > 0) @(posedge clock);
      repeat (TOTAL_LAT + 5) @(posedge clock);
   endtask

   task automatic add_point(input logic [7:0] ring, input logic [7:0] sector);
      point_type pt;
      pt.ring = ring;
      pt.sector = sector;
      point_q.insert(point_q.size(), pt);
   endtask

   // Mostly points on the grid, the rest anywhere in the 8-bit range so saturation is hit.
   task automatic add_random_points(input int n);
      int rl, sl;
      rl = (rings_reg < 2) ? 1 : (rings_reg > MAX_RINGS ? MAX_RINGS - 1 : rings_reg - 1);
      sl = (sectors_reg < 2) ? 1 : (sectors_reg > MAX_SECTORS ? MAX_SECTORS - 1 :
                                                                sectors_reg - 1);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(3) != 0)
            add_point(8'($urandom_range(rl)), 8'($urandom_range(sl)));
         else
            add_point(8'($urandom_range(255)), 8'($urandom_range(255)));
      end
   endtask

   logic [15:0] radius_set[8]  = '{16'd256, 16'hFFFF, 16'd0, 16'd1, 16'h8000, 16'd12345,
                                   16'd256, 16'h0000};
   logic [15:0] rings_set[8]   = '{16'd16, 16'd256, 16'd2, 16'd0, 16'hFFFF, 16'd3,
                                   16'hFE11, 16'd0};
   logic [15:0] sectors_set[8] = '{16'd16, 16'd256, 16'd2, 16'd1, 16'd300, 16'd255,
                                   16'd5, 16'd0};

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed points under the reset configuration: corners, edges, saturation.
      idle_pct = 20;
      add_point(8'd0, 8'd0);
      add_point(8'd255, 8'd255);
      add_point(8'd15, 8'd0);
      add_point(8'd0, 8'd15);
      add_point(8'd14, 8'd14);
      add_point(8'd15, 8'd15);
      add_point(8'd16, 8'd3);
      add_point(8'd3, 8'd16);
      add_point(8'd7, 8'd4);
      add_point(8'd8, 8'd12);
      add_point(8'd1, 8'd1);
      add_point(8'hAA, 8'h55);
      add_point(8'h55, 8'hAA);
      wait_drained();

      // The last setting draws random values for every register.
      radius_set[7] = 16'($urandom_range(65535));
      rings_set[7] = 16'($urandom_range(2, 256));
      sectors_set[7] = 16'($urandom_range(2, 256));

      for (int k = 1; k < 8; k++) begin
         // Sender idles at 20 percent, then 57 percent, then never.
         idle_pct = (k < 3) ? 20 : (k < 6) ? 57 : 0;
         write_reg(CSR_RADIUS, radius_set[k]);
         write_reg(CSR_RINGS, rings_set[k]);
         write_reg(CSR_SECTORS, sectors_set[k]);
         if (k == 4) write_reg(CSR_UNUSED, 16'hFFFF);
         end_writes();
         if (k == 1) begin
            // Largest grid: the far corners and the last quad.
            add_point(8'd255, 8'd255);
            add_point(8'd254, 8'd254);
            add_point(8'd0, 8'd255);
            add_point(8'd255, 8'd0);
            add_point(8'd128, 8'd64);
         end
         add_random_points(155);
         wait_drained();
         settings_run++;
      end

      $display("Checked %0d results for %0d grid points across %0d register settings.",
               checked, accepted, settings_run + 1);
      $display("Settings spanned 2 to 256 rings and sectors with radius from 0 to full scale.");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
